/* src/particle_drag_force_unit_macros.svh */
// Assertion macros used by the checker of the drag force unit
`ifndef PARTICLE_DRAG_FORCE_UNIT_MACROS_SVH
`define PARTICLE_DRAG_FORCE_UNIT_MACROS_SVH

// Implication in the same cycle
`define PDF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error("lbl failed");

// Implication in the next cycle
`define PDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error("lbl failed");

`endif

/* src/pdf_pkg.sv */
// Shared types and constants of the particle drag force unit
package pdf_pkg;

  localparam int unsigned VW      = 32;
  localparam int unsigned CW      = 31;
  localparam int unsigned FRAC    = 16;
  localparam int unsigned NCOMP   = 3;
  localparam int unsigned IDXW    = 2;

  localparam logic [IDXW-1:0] REG_LINEAR    = 2'd0;
  localparam logic [IDXW-1:0] REG_QUADRATIC = 2'd1;
  localparam logic [IDXW-1:0] REG_AIRBRAKE  = 2'd2;

  // sign and magnitude of one velocity vector
  typedef struct packed {
    logic [NCOMP-1:0]       neg;
    logic [NCOMP-1:0][VW-1:0] mag;
  } item_t;

  typedef struct packed {
    logic [CW-1:0] k1;
    logic [CW-1:0] k2;
    logic          airbrake;
  } cfg_t;

endpackage

/* src/pdf_front.sv */
// Front end: takes velocity items and splits them into sign and magnitude
module pdf_front
  import pdf_pkg::*;
(
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [31:0]   in_vel_x,
  input  logic [31:0]   in_vel_y,
  input  logic [31:0]   in_vel_z,
  input  logic          q_full,
  output logic          q_push,
  output item_t         q_data
);

  logic [NCOMP-1:0][VW-1:0] raw;

  assign raw      = {in_vel_z, in_vel_y, in_vel_x};
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    for (int i = 0; i < NCOMP; i++) begin
      q_data.neg[i] = raw[i][VW-1];
      // most negative value maps to 2^31, which still fits unsigned
      q_data.mag[i] = raw[i][VW-1] ? (~raw[i] + 32'd1) : raw[i];
    end
  end

endmodule

/* src/pdf_queue.sv */
// Small item queue between the front end and the arithmetic back end
module pdf_queue
  import pdf_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_data,
  output logic  full,
  input  logic  pop,
  output item_t pop_data,
  output logic  empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t             mem_r [DEPTH];
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic [AW-1:0]     rptr_r, rptr_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == (AW+1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH-1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH-1)) ? '0 : rptr_r + AW'(1);
    end
    cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

/* src/pdf_back.sv */
// Back end: speed, drag scale and saturated force, one item per cycle while the output is not stalled
module pdf_back
  import pdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  item_t       q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_force_x,
  output logic [31:0] out_force_y,
  output logic [31:0] out_force_z,
  output logic        out_saturated
);

  localparam int unsigned NSQ = VW;

  logic adv;

  // stage A: squares
  logic                       v_a_r;
  item_t                      it_a_r;
  logic [NCOMP-1:0][63:0]     sq_a_r;
  // stage B: sum of squares
  logic                       v_b_r;
  item_t                      it_b_r;
  logic [63:0]                sum_b_r;
  // square root, one result bit per stage
  logic                       v_s_r   [NSQ];
  item_t                      it_s_r  [NSQ];
  logic [63:0]                rem_s_r [NSQ];
  logic [VW-1:0]              root_s_r[NSQ];
  // stage Q: quadratic product
  logic                       v_q_r;
  item_t                      it_q_r;
  logic [62:0]                q_q_r;
  // stage C: scale
  logic                       v_c_r;
  item_t                      it_c_r;
  logic [48:0]                c_c_r;
  // stage P: partial products
  logic                       v_p_r;
  logic [NCOMP-1:0]           neg_p_r;
  logic [NCOMP-1:0][63:0]     plo_p_r;
  logic [NCOMP-1:0][48:0]     phi_p_r;
  // output register
  logic                       out_valid_r;
  logic [NCOMP-1:0][31:0]     force_r, force_nxt;
  logic                       sat_r, sat_nxt;

  assign adv   = !(out_valid_r && out_stall);
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (adv) begin
      it_a_r <= q_data;
      for (int i = 0; i < NCOMP; i++) begin
        sq_a_r[i] <= q_data.mag[i] * q_data.mag[i];
      end
      it_b_r  <= it_a_r;
      sum_b_r <= sq_a_r[0] + sq_a_r[1] + sq_a_r[2];
    end
  end

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam int unsigned B = NSQ - 1 - j;
    logic [63:0]   rem_in;
    logic [VW-1:0] root_in;
    item_t         it_in;
    logic          v_in;
    logic [65:0]   trial;
    logic          take;

    if (j == 0) begin : g_first
      assign rem_in  = sum_b_r;
      assign root_in = '0;
      assign it_in   = it_b_r;
      assign v_in    = v_b_r;
    end else begin : g_rest
      assign rem_in  = rem_s_r[j-1];
      assign root_in = root_s_r[j-1];
      assign it_in   = it_s_r[j-1];
      assign v_in    = v_s_r[j-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ({34'd0, root_in} << (B + 1)) + (66'd1 << (2 * B));
    assign take  = ({2'b00, rem_in} >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        it_s_r[j]   <= it_in;
        rem_s_r[j]  <= take ? (rem_in - trial[63:0]) : rem_in;
        root_s_r[j] <= take ? (root_in | (VW'(1) << B)) : root_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s_r[j] <= 1'b0;
      end else if (adv) begin
        v_s_r[j] <= v_in;
      end
    end
  end

  logic [63:0] q2;
  assign q2 = cfg.airbrake ? {q_q_r, 1'b0} : {1'b0, q_q_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      it_q_r <= it_s_r[NSQ-1];
      q_q_r  <= cfg.k2 * root_s_r[NSQ-1];
      it_c_r <= it_q_r;
      c_c_r  <= {18'd0, cfg.k1} + {1'b0, q2[63:FRAC]};
      neg_p_r <= it_c_r.neg;
      for (int i = 0; i < NCOMP; i++) begin
        plo_p_r[i] <= it_c_r.mag[i] * c_c_r[31:0];
        phi_p_r[i] <= it_c_r.mag[i] * c_c_r[48:32];
      end
      force_r <= force_nxt;
      sat_r   <= sat_nxt;
    end
  end

  always_comb begin
    logic        over;
    logic [48:0] mag;
    logic [48:0] limit;
    logic [63:0] rnd;
    sat_nxt = 1'b0;
    for (int i = 0; i < NCOMP; i++) begin
      rnd   = plo_p_r[i] + 64'd32768;
      mag   = {phi_p_r[i][32:0], 16'd0} + {1'b0, rnd[63:FRAC]};
      limit = neg_p_r[i] ? 49'h0_7FFF_FFFF : 49'h0_8000_0000;
      over  = (phi_p_r[i][48:32] != '0) || (mag > limit);
      if (over) begin
        mag = limit;
      end
      sat_nxt      = sat_nxt | over;
      // force has the sign opposite to the velocity
      force_nxt[i] = neg_p_r[i] ? mag[31:0] : (32'd0 - mag[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      v_q_r       <= 1'b0;
      v_c_r       <= 1'b0;
      v_p_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_a_r       <= q_pop;
      v_b_r       <= v_a_r;
      v_q_r       <= v_s_r[NSQ-1];
      v_c_r       <= v_q_r;
      v_p_r       <= v_c_r;
      out_valid_r <= v_p_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_force_x   = force_r[0];
  assign out_force_y   = force_r[1];
  assign out_force_z   = force_r[2];
  assign out_saturated = sat_r;

endmodule

/* src/particle_drag_force_unit.sv */
// Top level of the particle drag force unit
// Takes one velocity vector per cycle while the input is not stalled and
// returns the linear plus quadratic drag force on it in signed Q16.16, one
// result per item, in order. An accepted item passes through the input
// queue, squares and sum, 32 square root stages that resolve one bit of
// the speed each, then the coefficient product, the scale, the component
// products and the saturating output register. The square root stages
// make up most of the pipeline. A 4-entry queue behind the input keeps
// accepting while the output is stalled, until it is full. Write the
// coefficient registers only while no item is in flight.
module particle_drag_force_unit
  import pdf_pkg::*;
#(
  parameter int unsigned QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_vel_x,
  input  logic [31:0] in_vel_y,
  input  logic [31:0] in_vel_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_force_x,
  output logic [31:0] out_force_y,
  output logic [31:0] out_force_z,
  output logic        out_saturated
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_full, q_push, q_pop, q_empty;
  item_t q_wdata, q_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LINEAR:    cfg_nxt.k1       = cfg_wdata;
        REG_QUADRATIC: cfg_nxt.k2       = cfg_wdata;
        REG_AIRBRAKE:  cfg_nxt.airbrake = cfg_wdata[0];
        default:       cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pdf_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_vel_x (in_vel_x),
    .in_vel_y (in_vel_y),
    .in_vel_z (in_vel_z),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  pdf_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  pdf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_force_x   (out_force_x),
    .out_force_y   (out_force_y),
    .out_force_z   (out_force_z),
    .out_saturated (out_saturated)
  );

endmodule

/* src/pdf_checker.sv */
// Port-level checker of the particle drag force unit and its bind
`include "particle_drag_force_unit_macros.svh"

module pdf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_force_x,
  input logic [31:0] out_force_y,
  input logic [31:0] out_force_z,
  input logic        out_saturated
);

  // a stalled result holds
  `PDF_ASSERT_NEXT(a_out_hold, rst_n && out_valid && out_stall, !rst_n || (out_valid && $stable(out_force_x) && $stable(out_force_y) && $stable(out_force_z) && $stable(out_saturated)))
  // pipeline is empty right after reset
  `PDF_ASSERT_NOW(a_out_clear, rst_n && ($past(rst_n) == 1'b0), !out_valid)
  // queue is empty right after reset
  `PDF_ASSERT_NOW(a_in_open, rst_n && ($past(rst_n) == 1'b0), !in_stall)

endmodule

bind particle_drag_force_unit pdf_checker u_pdf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_force_x   (out_force_x),
  .out_force_y   (out_force_y),
  .out_force_z   (out_force_z),
  .out_saturated (out_saturated)
);

/* bench/testbench.sv */
// Self-checking testbench for the particle drag force unit
`timescale 1ns / 100ps

module testbench;
  import pdf_pkg::*;

  typedef struct {
    logic [31:0] vx, vy, vz;
  } vel_t;

  typedef struct {
    logic [31:0] fx, fy, fz;
    logic        sat;
  } drag_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [30:0] wdata;
    vel_t        vel;
  } step_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_vel_x, in_vel_y, in_vel_z;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_force_x, out_force_y, out_force_z;
  logic        out_saturated;

  particle_drag_force_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_vel_z(in_vel_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_force_x(out_force_x), .out_force_y(out_force_y),
    .out_force_z(out_force_z), .out_saturated(out_saturated)
  );

  // predictor copy of the coefficient registers
  logic [30:0] k1_q, k2_q;
  logic        brake_q;

  step_t pending_q[$];
  drag_t expected_forces[$];
  int    n_items, n_results, n_cfg, n_sat, n_bad;
  int    hold_off;
  bit    stim_done;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] drag_comp(logic [31:0] v, logic [48:0] c,
                                            inout logic sat);
    logic        neg;
    logic [32:0] a;
    logic [95:0] prod, mag, lim;
    neg = v[31];
    a = neg ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    lim = neg ? 96'h7FFF_FFFF : 96'h8000_0000;
    prod = 96'(a) * 96'(c);
    mag = (prod + 96'h8000) >> FRAC;
    if (mag > lim) begin
      sat = 1'b1;
      mag = lim;
    end
    return neg ? mag[31:0] : 32'(33'h1_0000_0000 - {1'b0, mag[31:0]});
  endfunction

  function automatic drag_t predict_drag(vel_t v);
    drag_t       f;
    logic [63:0] sumsq, spd;
    logic [32:0] a;
    logic [95:0] q;
    logic [48:0] c;
    logic [31:0] comp[3];
    sumsq = 0;
    comp = '{v.vx, v.vy, v.vz};
    foreach (comp[i]) begin
      a = comp[i][31] ? (33'h1_0000_0000 - {1'b0, comp[i]}) : {1'b0, comp[i]};
      sumsq += 64'(a) * 64'(a);
    end
    spd = int_sqrt(sumsq);
    q = 96'(k2_q) * 96'(spd);
    if (brake_q) q = q * 2;
    c = 49'(k1_q) + 49'(q >> FRAC);
    f.sat = 1'b0;
    f.fx = drag_comp(v.vx, c, f.sat);
    f.fy = drag_comp(v.vy, c, f.sat);
    f.fz = drag_comp(v.vz, c, f.sat);
    return f;
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(0, 200000)) - 100000);
      3: return 32'($signed($urandom_range(0, 40)) - 20);
      4: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 600)) - 300) <<< 16;
    endcase
  endfunction

  function automatic logic [30:0] rand_coeff();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 4 << 16));
      1: return 31'($urandom_range(0, 1 << 12));
      2: return 31'($urandom);
      default: return 31'($urandom_range(0, 1 << 16));
    endcase
  endfunction

  task automatic push_vel(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    step_t s;
    s.is_cfg = 1'b0;
    s.vel.vx = x; s.vel.vy = y; s.vel.vz = z;
    pending_q.insert(pending_q.size(), s);
  endtask

  task automatic push_cfg(logic [1:0] idx, logic [30:0] d);
    step_t s;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.wdata = d;
    pending_q.insert(pending_q.size(), s);
  endtask

  // directed part, then random phases each opened by new register settings
  initial begin
    push_cfg(REG_LINEAR, 31'h0001_0000);
    push_cfg(REG_QUADRATIC, 31'h0000_8000);
    push_cfg(REG_AIRBRAKE, 31'd0);
    push_vel(0, 0, 0);
    push_vel(32'h0001_0000, 0, 0);
    push_vel(32'hFFFF_0000, 32'h0003_0000, 32'h0004_0000);
    push_vel(32'h7FFF_FFFF, 0, 0);
    push_vel(32'h8000_0000, 0, 0);
    push_vel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_vel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_vel(1, 32'hFFFF_FFFF, 0);
    push_vel(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001);
    push_cfg(REG_AIRBRAKE, 31'd1);
    push_vel(32'h0010_0000, 32'hFFF0_0000, 0);
    push_vel(32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_AAAA);
    push_cfg(REG_LINEAR, 31'h7FFF_FFFF);
    push_cfg(REG_QUADRATIC, 31'h7FFF_FFFF);
    push_vel(1, 0, 0);
    push_vel(0, 32'hFFFF_FFFF, 0);
    push_vel(32'h0000_0100, 32'hAAAA_5555, 0);
    push_cfg(REG_LINEAR, 31'd0);
    push_cfg(REG_QUADRATIC, 31'd0);
    push_cfg(REG_AIRBRAKE, 31'd0);
    push_vel(32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF);
    // out-of-range index must be ignored
    push_cfg(2'd3, 31'h7FFF_FFFF);
    push_cfg(REG_LINEAR, 31'h0000_4000);
    push_vel(32'h0100_0000, 0, 32'hFF00_0000);
    for (int p = 0; p < 13; p++) begin
      push_cfg(REG_LINEAR, p == 12 ? 31'h7FFF_FFFF : rand_coeff());
      push_cfg(REG_QUADRATIC, p == 11 ? 31'h0 : rand_coeff());
      push_cfg(REG_AIRBRAKE, 31'($urandom_range(0, 1)));
      for (int i = 0; i < 50; i++) push_vel(rand_vel(), rand_vel(), rand_vel());
    end
  end

  // driver: registers are written only with the pipe drained and a pause after
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_we   <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_forces.insert(expected_forces.size(), predict_drag(
          '{vx: in_vel_x, vy: in_vel_y, vz: in_vel_z}));
        n_items++;
      end
      // a write is never issued in the cycle right after another one
      if (cfg_we) cfg_we <= 1'b0;
      if ((!in_valid || !in_stall) && !stim_done) begin
        if (pending_q.size() == 0) begin
          in_valid  <= 1'b0;
          stim_done <= 1'b1;
        end else if (pending_q[0].is_cfg) begin
          in_valid <= 1'b0;
          if (!(in_valid && !in_stall) && expected_forces.size() == 0) begin
            if (hold_off < 45) begin
              hold_off <= hold_off + 1;
            end else begin
              step_t s;
              s = pending_q.pop_front();
              cfg_we    <= 1'b1;
              cfg_index <= s.idx;
              cfg_wdata <= s.wdata;
              n_cfg++;
              case (s.idx)
                REG_LINEAR:    k1_q = s.wdata;
                REG_QUADRATIC: k2_q = s.wdata;
                REG_AIRBRAKE:  brake_q = s.wdata[0];
                default: ;
              endcase
              hold_off <= 40;
            end
          end
        end else if (hold_off < 0) begin
          hold_off <= hold_off + 1;
          in_valid <= 1'b0;
        end else begin
          step_t s;
          s = pending_q.pop_front();
          in_valid <= 1'b1;
          in_vel_x <= s.vel.vx;
          in_vel_y <= s.vel.vy;
          in_vel_z <= s.vel.vz;
          hold_off <= ($urandom_range(0, 2) == 0) ? -$urandom_range(0, 10) : 0;
        end
      end
    end
  end

  // receiver stall: random gaps, quiet stretches, and one long hold-off
  int  stall_cnt;
  int  long_hold;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cnt <= 0;
      long_hold <= 0;
    end else if (long_hold == 0 && n_results >= 60) begin
      out_stall <= 1'b1;
      long_hold <= 1;
      stall_cnt <= 200;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall || !out_valid) begin
      if ((n_results / 100) % 2 == 1) begin
        out_stall <= 1'b0;
      end else begin
        stall_cnt <= $urandom_range(0, 10);
        out_stall <= 1'($urandom_range(0, 1));
      end
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      drag_t e;
      n_results++;
      if (expected_forces.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %h %h %h", out_force_x,
                                  out_force_y, out_force_z);
      end else begin
        e = expected_forces.pop_front();
        if (out_saturated) n_sat++;
        if (e.fx !== out_force_x || e.fy !== out_force_y || e.fz !== out_force_z
            || e.sat !== out_saturated) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp %h %h %h sat %b, got %h %h %h sat %b",
                     e.fx, e.fy, e.fz, e.sat, out_force_x, out_force_y,
                     out_force_z, out_saturated);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_vel_x = '0; in_vel_y = '0; in_vel_z = '0;
    k1_q = '0; k2_q = '0; brake_q = 1'b0;
    n_items = 0; n_results = 0; n_cfg = 0; n_sat = 0; n_bad = 0;
    hold_off = 0;
    stim_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && expected_forces.size() == 0);
    repeat (60) @(posedge clk);
    n_bad += expected_forces.size();
    $display("%0d velocity items, %0d results (%0d saturated), %0d register writes",
             n_items, n_results, n_sat, n_cfg);
    $display("covered zero and extreme vectors, airbrake on and off, full coefficients");
    if (n_bad == 0) begin
      $display("particle_drag_force_unit verification clean");
    end else begin
      $display("particle_drag_force_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("particle_drag_force_unit verification failed");
    $finish;
  end

endmodule
